// ===== hdl/multi_window_moving_average_macros.svh =====
// Assertion macros shared by the moving-average RTL.
`ifndef MULTI_WINDOW_MOVING_AVERAGE_MACROS_SVH
`define MULTI_WINDOW_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MWMA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MWMA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mwma_pkg.sv =====
// Package: sizes, window tables, reciprocal constants and shared types.
package mwma_pkg;

   localparam int RING_DEPTH  = 128;
   localparam int SAMPLE_BITS = 16;
   localparam int AVG_BITS    = 16;

   localparam int PTR_BITS  = $clog2(RING_DEPTH);
   localparam int FILL_BITS = $clog2(RING_DEPTH + 1);

   // Nested averaging windows, shortest first.
   localparam int WIN_COUNT = 7;
   localparam int WIN_BITS  = $clog2(WIN_COUNT + 1);
   localparam int WIN_LEN   [WIN_COUNT] = '{2, 4, 8, 12, 25, 60, 125};
   localparam int WIN_SHIFT [WIN_COUNT] = '{$clog2(2), $clog2(4), $clog2(8), $clog2(12),
                                            $clog2(25), $clog2(60), $clog2(125)};
   localparam int WIN_MAX   = WIN_LEN[WIN_COUNT-1];
   localparam int CNT_BITS  = $clog2(WIN_MAX + 1);

   // Running sum of the longest window fits here.
   localparam int SUM_BITS  = SAMPLE_BITS + WIN_SHIFT[WIN_COUNT-1];
   localparam int MAG_BITS  = SUM_BITS + 1;
   localparam int PROD_BITS = SUM_BITS + MAG_BITS;

   // Reciprocals ceil(2^(SUM_BITS+l)/N), l = clog2(N): floor(x*m >> (SUM_BITS+l)) == x/N
   localparam logic [63:0] WIN_MAGIC [WIN_COUNT] = '{
      ((64'd1 << (SUM_BITS + WIN_SHIFT[0])) + 64'(WIN_LEN[0]) - 64'd1) / 64'(WIN_LEN[0]),
      ((64'd1 << (SUM_BITS + WIN_SHIFT[1])) + 64'(WIN_LEN[1]) - 64'd1) / 64'(WIN_LEN[1]),
      ((64'd1 << (SUM_BITS + WIN_SHIFT[2])) + 64'(WIN_LEN[2]) - 64'd1) / 64'(WIN_LEN[2]),
      ((64'd1 << (SUM_BITS + WIN_SHIFT[3])) + 64'(WIN_LEN[3]) - 64'd1) / 64'(WIN_LEN[3]),
      ((64'd1 << (SUM_BITS + WIN_SHIFT[4])) + 64'(WIN_LEN[4]) - 64'd1) / 64'(WIN_LEN[4]),
      ((64'd1 << (SUM_BITS + WIN_SHIFT[5])) + 64'(WIN_LEN[5]) - 64'd1) / 64'(WIN_LEN[5]),
      ((64'd1 << (SUM_BITS + WIN_SHIFT[6])) + 64'(WIN_LEN[6]) - 64'd1) / 64'(WIN_LEN[6])
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Request into the constant divider.
   typedef struct packed {
      logic                go;
      logic [WIN_BITS-1:0] win;
      logic [SUM_BITS-1:0] sum;
   } div_req_type;

   // Result and status out of the constant divider.
   typedef struct packed {
      logic                   done;
      logic                   busy;
      logic [WIN_BITS-1:0]    win;
      logic [SAMPLE_BITS-1:0] quot;
   } div_rsp_type;

endpackage

// ===== hdl/mwma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mwma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mwma_cdiv.sv =====
// Shared two-stage divider by the window lengths (reciprocal multiply and shift).
module mwma_cdiv (
   input  logic                 clock,
   input  logic                 reset,
   input  mwma_pkg::div_req_type div_req,
   output mwma_pkg::div_rsp_type div_rsp
);

   logic                             go1_ff;
   logic [mwma_pkg::WIN_BITS-1:0]    win1_ff;
   logic [mwma_pkg::SUM_BITS-1:0]    x_ff;
   logic                             go2_ff;
   logic [mwma_pkg::WIN_BITS-1:0]    win2_ff;
   logic [mwma_pkg::PROD_BITS-1:0]   prod_ff;
   logic [mwma_pkg::MAG_BITS-1:0]    mag;
   logic [mwma_pkg::PROD_BITS-1:0]   prod_in;
   logic [mwma_pkg::PROD_BITS-1:0]   shifted;

   // Pick the reciprocal of the window being divided
   assign mag     = mwma_pkg::MAG_BITS'(mwma_pkg::WIN_MAGIC[win1_ff]);
   assign prod_in = mwma_pkg::PROD_BITS'(x_ff) * mwma_pkg::PROD_BITS'(mag);

   // Advance the stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         go1_ff <= 1'b0;
         go2_ff <= 1'b0;
      end else begin
         go1_ff <= div_req.go;
         go2_ff <= go1_ff;
      end
   end

   // Capture the operand, then the product
   always_ff @(posedge clock) begin
      if (div_req.go) begin
         x_ff    <= div_req.sum;
         win1_ff <= div_req.win;
      end
      if (go1_ff) begin
         prod_ff <= prod_in;
         win2_ff <= win1_ff;
      end
   end

   // Drop the fraction bits
   assign shifted = prod_ff >> (mwma_pkg::SUM_BITS + mwma_pkg::WIN_SHIFT[win2_ff]);

   assign div_rsp.done = go2_ff;
   assign div_rsp.busy = go1_ff | go2_ff;
   assign div_rsp.win  = win2_ff;
   assign div_rsp.quot = mwma_pkg::SAMPLE_BITS'(shifted);

endmodule

// ===== hdl/multi_window_moving_average.sv =====
// Top level: sample ring, window accumulation sequencer and result register.
// Per sample: 125 ring reads folded through one adder behind a registered read, then the
// two-stage divider, a drain check and a load of the result register.
// The single ring read port walks 125 entries per sample, and no new sample is taken
// until the last one's result is loaded. A new sample may be taken while the last
// result waits. Reset (synchronous, active high) empties the ring by clearing the fill count.
`include "multi_window_moving_average_macros.svh"

module multi_window_moving_average (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_avg_2,
   output logic [15:0] rsp_avg_4,
   output logic [15:0] rsp_avg_8,
   output logic [15:0] rsp_avg_12,
   output logic [15:0] rsp_avg_25,
   output logic [15:0] rsp_avg_60,
   output logic [15:0] rsp_avg_125
);

   mwma_pkg::state_type state_ff, state_in;

   logic [mwma_pkg::PTR_BITS-1:0]    pos_ff, pos_in;
   logic [mwma_pkg::FILL_BITS-1:0]   fill_ff, fill_in;
   logic [mwma_pkg::PTR_BITS-1:0]    rd_pos_ff, rd_pos_in;
   logic [mwma_pkg::CNT_BITS-1:0]    issue_cnt_ff, issue_cnt_in;
   logic                             rd_live_ff, rd_live_in;
   logic                             rd_keep_ff, rd_keep_in;
   logic [mwma_pkg::CNT_BITS-1:0]    taken_ff, taken_in;
   logic [mwma_pkg::SUM_BITS-1:0]    sum_ff, sum_in;
   logic [mwma_pkg::WIN_BITS-1:0]    win_idx_ff, win_idx_in;
   logic [mwma_pkg::SAMPLE_BITS-1:0] avg_ff [mwma_pkg::WIN_COUNT];
   logic [mwma_pkg::AVG_BITS-1:0]    rsp_avg_ff [mwma_pkg::WIN_COUNT];
   logic                             rsp_valid_ff, rsp_valid_in;

   logic                             req_accept;
   logic                             rsp_take;
   logic                             rsp_load;
   logic                             in_sum;
   logic                             issue;
   logic [mwma_pkg::PTR_BITS-1:0]    pos_next;
   logic [mwma_pkg::PTR_BITS-1:0]    rd_pos_prev;
   logic                             entry_written;
   logic [mwma_pkg::SAMPLE_BITS-1:0] rd_data;
   logic [mwma_pkg::SAMPLE_BITS-1:0] addend;
   logic [mwma_pkg::SUM_BITS-1:0]    sum_next;
   logic [mwma_pkg::CNT_BITS-1:0]    taken_next;
   logic                             win_ok;
   logic [mwma_pkg::WIN_BITS-1:0]    win_sel;
   logic                             win_close;
   logic                             last_take;
   mwma_pkg::div_req_type            div_req;
   mwma_pkg::div_rsp_type            div_rsp;

   assign req_accept = req_valid & ~req_stall;
   assign rsp_take   = rsp_valid_ff & ~rsp_stall;

   // Ring pointer arithmetic with wrap
   assign pos_next    = (pos_ff == mwma_pkg::PTR_BITS'(mwma_pkg::RING_DEPTH - 1))
                        ? '0 : pos_ff + 1'b1;
   assign rd_pos_prev = (rd_pos_ff == '0)
                        ? mwma_pkg::PTR_BITS'(mwma_pkg::RING_DEPTH - 1) : rd_pos_ff - 1'b1;

   // Entries never written since reset read as zero
   assign entry_written = (fill_ff == mwma_pkg::FILL_BITS'(mwma_pkg::RING_DEPTH)) ||
                          ((rd_pos_ff != '0) && (mwma_pkg::FILL_BITS'(rd_pos_ff) <= fill_ff));

   mwma_ram #(
      .WIDTH (mwma_pkg::SAMPLE_BITS),
      .DEPTH (mwma_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (pos_next),
      .wr_data (mwma_pkg::SAMPLE_BITS'(req_sample)),
      .rd_addr (rd_pos_ff),
      .rd_data (rd_data)
   );

   // Shared adder: fold one ring entry per cycle into the running sum
   assign issue      = in_sum && (issue_cnt_ff != mwma_pkg::CNT_BITS'(mwma_pkg::WIN_MAX));
   assign addend     = rd_keep_ff ? rd_data : '0;
   assign sum_next   = sum_ff + mwma_pkg::SUM_BITS'(addend);
   assign taken_next = taken_ff + 1'b1;
   assign win_ok     = (win_idx_ff != mwma_pkg::WIN_BITS'(mwma_pkg::WIN_COUNT));
   assign win_sel    = win_ok ? win_idx_ff : mwma_pkg::WIN_BITS'(mwma_pkg::WIN_COUNT - 1);
   assign win_close  = rd_live_ff && win_ok &&
                       (taken_next == mwma_pkg::CNT_BITS'(mwma_pkg::WIN_LEN[win_sel]));
   assign last_take  = rd_live_ff &&
                       (taken_next == mwma_pkg::CNT_BITS'(mwma_pkg::WIN_MAX));

   // Hand each closed window's sum to the divider
   assign div_req.go  = win_close;
   assign div_req.win = win_idx_ff;
   assign div_req.sum = sum_next;

   mwma_cdiv u_cdiv (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mwma_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = mwma_pkg::ST_SUM;
            end
         end
         mwma_pkg::ST_SUM: begin
            if (last_take) begin
               state_in = mwma_pkg::ST_DRAIN;
            end
         end
         mwma_pkg::ST_DRAIN: begin
            if (!div_rsp.busy) begin
               state_in = mwma_pkg::ST_DONE;
            end
         end
         mwma_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_take) begin
               state_in = mwma_pkg::ST_IDLE;
            end
         end
         default: state_in = mwma_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      in_sum    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         mwma_pkg::ST_IDLE:  req_stall = 1'b0;
         mwma_pkg::ST_SUM:   in_sum    = 1'b1;
         mwma_pkg::ST_DRAIN: req_stall = 1'b1;
         mwma_pkg::ST_DONE:  rsp_load  = !rsp_valid_ff || rsp_take;
         default:            req_stall = 1'b1;
      endcase
   end

   // Datapath next values
   always_comb begin
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      rd_pos_in    = rd_pos_ff;
      issue_cnt_in = issue_cnt_ff;
      taken_in     = taken_ff;
      sum_in       = sum_ff;
      win_idx_in   = win_idx_ff;
      rd_live_in   = issue;
      rd_keep_in   = entry_written;
      if (req_accept) begin
         pos_in       = pos_next;
         if (fill_ff != mwma_pkg::FILL_BITS'(mwma_pkg::RING_DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
         rd_pos_in    = pos_next;
         issue_cnt_in = '0;
         taken_in     = '0;
         sum_in       = '0;
         win_idx_in   = '0;
      end
      if (issue) begin
         rd_pos_in    = rd_pos_prev;
         issue_cnt_in = issue_cnt_ff + 1'b1;
      end
      if (rd_live_ff) begin
         sum_in   = sum_next;
         taken_in = taken_next;
      end
      if (win_close) begin
         win_idx_in = win_idx_ff + 1'b1;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_take);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwma_pkg::ST_IDLE;
         pos_ff       <= '0;
         fill_ff      <= '0;
         issue_cnt_ff <= '0;
         taken_ff     <= '0;
         win_idx_ff   <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         issue_cnt_ff <= issue_cnt_in;
         taken_ff     <= taken_in;
         win_idx_ff   <= win_idx_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_pos_ff  <= rd_pos_in;
      rd_keep_ff <= rd_keep_in;
      sum_ff     <= sum_in;
      if (div_rsp.done) begin
         avg_ff[div_rsp.win] <= div_rsp.quot;
      end
      if (rsp_load) begin
         for (int i = 0; i < mwma_pkg::WIN_COUNT; i++) begin
            rsp_avg_ff[i] <= mwma_pkg::AVG_BITS'(avg_ff[i]);
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_avg_2   = rsp_avg_ff[0];
   assign rsp_avg_4   = rsp_avg_ff[1];
   assign rsp_avg_8   = rsp_avg_ff[2];
   assign rsp_avg_12  = rsp_avg_ff[3];
   assign rsp_avg_25  = rsp_avg_ff[4];
   assign rsp_avg_60  = rsp_avg_ff[5];
   assign rsp_avg_125 = rsp_avg_ff[6];

   // Checks
   `MWMA_ASSERT_NXT(a_start_walk, req_accept, (state_ff == mwma_pkg::ST_SUM) && (issue_cnt_ff == '0) && (taken_ff == '0), "walk did not restart after a transaction")
   `MWMA_ASSERT_IMP(a_all_windows, state_ff == mwma_pkg::ST_DONE, win_idx_ff == mwma_pkg::WIN_BITS'(mwma_pkg::WIN_COUNT), "result ready before every window closed")
   `MWMA_ASSERT_IMP(a_div_window, div_rsp.done, (state_ff == mwma_pkg::ST_SUM) || (state_ff == mwma_pkg::ST_DRAIN), "divider result outside accumulation")
   `MWMA_ASSERT_IMP(a_fill_limit, 1'b1, fill_ff <= mwma_pkg::FILL_BITS'(mwma_pkg::RING_DEPTH), "fill count past ring depth")

endmodule

// ===== sim/tb_multi_window_moving_average.sv =====
// Testbench for the multi-window moving average: in-bench predictor and result scoreboard.
module tb_multi_window_moving_average;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH  = mwma_pkg::RING_DEPTH;
   localparam int SAMPLE_BITS = mwma_pkg::SAMPLE_BITS;
   localparam int N_WINDOWS   = 7;
   localparam int WINDOW_SIZE [N_WINDOWS] = '{2, 4, 8, 12, 25, 60, 125};

   typedef logic [N_WINDOWS-1:0][15:0] mean_set_type;

   typedef enum int {
      PAT_UNIFORM,
      PAT_FULL_SCALE,
      PAT_ZERO,
      PAT_NEAR_EDGE,
      PAT_RAMP
   } sample_pattern_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [15:0] req_sample  = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [15:0] rsp_avg_2;
   logic [15:0] rsp_avg_4;
   logic [15:0] rsp_avg_8;
   logic [15:0] rsp_avg_12;
   logic [15:0] rsp_avg_25;
   logic [15:0] rsp_avg_60;
   logic [15:0] rsp_avg_125;

   // Predictor state: mirror of the sample ring and its newest position
   logic [SAMPLE_BITS-1:0] ring_mirror [RING_DEPTH] = '{default: '0};
   int unsigned            newest_idx = 0;
   mean_set_type           means_pending [$];

   // Idle control shared by the stimulus and the receiver
   bit tx_idle_on     = 1'b1;
   bit rx_idle_on     = 1'b1;
   int rx_hold_cycles = 0;

   int samples_sent    = 0;
   int results_checked = 0;
   int error_count     = 0;

   multi_window_moving_average i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_avg_2   (rsp_avg_2),
      .rsp_avg_4   (rsp_avg_4),
      .rsp_avg_8   (rsp_avg_8),
      .rsp_avg_12  (rsp_avg_12),
      .rsp_avg_25  (rsp_avg_25),
      .rsp_avg_60  (rsp_avg_60),
      .rsp_avg_125 (rsp_avg_125)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Advance the mirror ring, store the sample and queue the seven nested means
   function automatic void predict_means(input logic [15:0] value);
      mean_set_type m;
      logic [31:0]  sum;
      int unsigned  pos;
      int unsigned  taken;
      int           w;
      newest_idx = (newest_idx == RING_DEPTH - 1) ? 0 : newest_idx + 1;
      ring_mirror[newest_idx] = value[SAMPLE_BITS-1:0];
      pos   = newest_idx;
      sum   = '0;
      taken = 0;
      for (w = 0; w < N_WINDOWS; w++) begin
         // walk backward from the newest entry, wrapping below entry zero
         while (taken < WINDOW_SIZE[w]) begin
            sum += ring_mirror[pos];
            pos = (pos == 0) ? RING_DEPTH - 1 : pos - 1;
            taken++;
         end
         m[w] = 16'(sum / taken);
      end
      means_pending.push_back(m);
   endfunction

   // Offer one sample, hold it until accepted, then record its expected means
   task automatic send_sample(input logic [15:0] value);
      int gap;
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      predict_means(value);
      samples_sent++;
   endtask

   // Drop the request and wait until every expected result has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (means_pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample(input sample_pattern_type pat,
                                               inout logic [15:0] ramp,
                                               input logic [15:0] step);
      case (pat)
         PAT_FULL_SCALE: return 16'hFFFF;
         PAT_ZERO:       return 16'h0000;
         PAT_NEAR_EDGE: begin
            if ($urandom_range(0, 1) == 1)
               return 16'(16'hFFFF - $urandom_range(0, 3));
            return 16'($urandom_range(0, 3));
         end
         PAT_RAMP: begin
            ramp = ramp + step;
            return ramp;
         end
         default: return 16'($urandom);
      endcase
   endfunction

   // Extremes, alternating bit patterns and early items that still see cleared entries
   task automatic test_directed_extremes();
      logic [15:0] seq [$];
      seq = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000,
              16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFE, 16'h0001};
      repeat (13) seq.push_back(16'hFFFF);
      foreach (seq[k]) send_sample(seq[k]);
   endtask

   // Hold off results for a long stretch while samples keep coming, so the input stalls
   task automatic test_result_holdoff();
      rx_hold_cycles = 800;
      repeat (6) send_sample(16'($urandom));
      wait_for_drain();
   endtask

   // Pause the sender until every outstanding result has come back, several times
   task automatic test_drain_pause();
      repeat (5) begin
         repeat (4) send_sample(16'($urandom));
         wait_for_drain();
      end
   endtask

   // Segments of uniform, constant full-scale, zero, near-edge and ramp samples
   task automatic test_random_mix(input int count);
      sample_pattern_type pat;
      int                 seg_left;
      int                 pick;
      logic [15:0]        ramp;
      logic [15:0]        step;
      seg_left = 0;
      pat      = PAT_UNIFORM;
      ramp     = '0;
      step     = '0;
      repeat (count) begin
         if (seg_left == 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
               4:       pat = PAT_FULL_SCALE;
               5:       pat = PAT_ZERO;
               6:       pat = PAT_NEAR_EDGE;
               7, 8:    pat = PAT_RAMP;
               default: pat = PAT_UNIFORM;
            endcase
            // constant runs long enough to fill the widest window
            if (pat == PAT_FULL_SCALE || pat == PAT_ZERO)
               seg_left = $urandom_range(125, 200);
            else
               seg_left = $urandom_range(8, 160);
            ramp = 16'($urandom);
            step = 16'($urandom_range(1, 2000));
         end
         send_sample(pick_sample(pat, ramp, step));
         seg_left--;
      end
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_no_idle(input int count);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (count) send_sample(16'($urandom));
   endtask

   // Receiver: long hold-off on request, otherwise random stall bursts
   initial begin : result_stall_gen
      int n;
      forever begin
         @(posedge clock);
         if (rx_hold_cycles > 0) begin
            n = rx_hold_cycles;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rx_hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result with the oldest expected means
   initial begin : result_checker
      mean_set_type want;
      mean_set_type got;
      int           w;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = {rsp_avg_125, rsp_avg_60, rsp_avg_25, rsp_avg_12,
                   rsp_avg_8, rsp_avg_4, rsp_avg_2};
            if (means_pending.size() == 0) begin
               $display("%0t: unexpected result transaction, actual avg_2 %0d",
                        $realtime, got[0]);
               error_count++;
            end else begin
               want = means_pending.pop_front();
               for (w = 0; w < N_WINDOWS; w++) begin
                  if (got[w] !== want[w]) begin
                     $display("%0t: avg_%0d mismatch, expected %0d actual %0d",
                              $realtime, WINDOW_SIZE[w], want[w], got[w]);
                     error_count++;
                  end
               end
               results_checked++;
            end
         end
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("%0t: timeout with %0d results outstanding", $realtime,
               means_pending.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin : main_seq
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_result_holdoff();
      test_drain_pause();
      test_random_mix(1600);
      test_no_idle(150);

      wait_for_drain();
      repeat (200) @(posedge clock);

      $display("Sent %0d samples and checked %0d results: extremes, zero-filled early",
               samples_sent, results_checked);
      $display("windows, ring wrap, full-scale sums, long result hold-off and drain pauses.");
      if (error_count == 0 && means_pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mwma_pkg.sv
hdl/mwma_ram.sv
hdl/mwma_cdiv.sv
hdl/multi_window_moving_average.sv
sim/tb_multi_window_moving_average.sv
